@@ hdl/isl_pkg.sv @@
// ----------------------------------------------------------------------------
// isl_pkg
// Shared types and codes for the indexed sequence list: operation codes,
// status codes, controller states and the per-cell control bundle.
// ----------------------------------------------------------------------------
package isl_pkg;

    // Operation codes carried by s_func
    localparam logic [1:0] OP_INSERT    = 2'd0;
    localparam logic [1:0] OP_REMOVE    = 2'd1;
    localparam logic [1:0] OP_OVERWRITE = 2'd2;
    localparam logic [1:0] OP_READ      = 2'd3;

    // Status codes reported on m_status
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } state_t;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic load;    // a transfer is taken this cycle
        logic ins;     // shift toward the tail and place the new word
        logic rem;     // shift toward the head over the target
        logic wr;      // overwrite the target
        logic rd;      // capture the target without change
    } cell_ctl_t;

endpackage

@@ hdl/isl_cell.sv @@
// ----------------------------------------------------------------------------
// isl_cell
// One storage cell of the list chain. Holds one word, takes its left or
// right neighbor on a shift, and captures its word into a tap on a hit.
// ----------------------------------------------------------------------------
module isl_cell
    import isl_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int CMP_W      = 5,
    parameter int INDEX      = 0
) (
    input  logic                  aclk,
    input  cell_ctl_t             ctl,
    input  logic [CMP_W-1:0]      eff_pos,
    input  logic [DATA_WIDTH-1:0] word,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] tap
);

    localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic [DATA_WIDTH-1:0] tap_reg;
    logic [DATA_WIDTH-1:0] tap_next;
    logic                  hit;
    logic                  above;

    assign hit   = (IDX == eff_pos);
    assign above = (IDX > eff_pos);

    // Select the next word: shift, write or hold
    always_comb begin
        data_next = data_reg;
        if (ctl.ins) begin
            if (above) begin
                data_next = left_data;
            end else if (hit) begin
                data_next = word;
            end
        end else if (ctl.rem) begin
            if (hit || above) begin
                data_next = right_data;
            end
        end else if (ctl.wr) begin
            if (hit) begin
                data_next = word;
            end
        end
    end

    // On a transfer, capture the old word on a hit for remove and read, zero otherwise
    always_comb begin
        tap_next = tap_reg;
        if (ctl.load) begin
            tap_next = ((ctl.rem || ctl.rd) && hit) ? data_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        tap_reg  <= tap_next;
    end

    assign data = data_reg;
    assign tap  = tap_reg;

endmodule

@@ hdl/isl_reduce.sv @@
// ----------------------------------------------------------------------------
// isl_reduce
// Merge the cell taps into one word. At most one tap is nonzero, so an OR
// over all taps yields the removed or read word.
// ----------------------------------------------------------------------------
module isl_reduce #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic [DEPTH-1:0][DATA_WIDTH-1:0] taps,
    output logic [DATA_WIDTH-1:0]            word
);

    // OR the taps together
    always_comb begin
        word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            word = word | taps[i];
        end
    end

endmodule

@@ hdl/indexed_sequence_list_top.sv @@
// ----------------------------------------------------------------------------
// indexed_sequence_list_top
// Ordered list of up to DEPTH words with insert, remove, overwrite and read
// at a position, built as a shifting chain of cells.
// ----------------------------------------------------------------------------
// For each item, in the cycle of the input transfer every cell shifts,
// writes or holds at once and the target cell captures its old word into
// its tap; then, once the output register is free, the taps are merged
// into the output register. The input is not ready while an item is in
// flight, but is ready again while that result waits to be taken. Positions
// at or past the end mean the end. No clearing pass is needed after reset:
// only the count is reset, and cells beyond it are never read.
module indexed_sequence_list_top
    import isl_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [4:0]  s_position,
    input  logic [31:0] s_word_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_word_out,
    output logic [1:0]  m_status,
    output logic [4:0]  m_count,
    output logic        m_is_empty
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    state_t                          state_reg;
    state_t                          state_next;
    logic [CNT_W-1:0]                count_reg;
    logic [CNT_W-1:0]                count_next;
    logic [1:0]                      pend_status_reg;
    logic [1:0]                      pend_status_next;
    logic                            m_valid_reg;
    logic [31:0]                     m_word_out_reg;
    logic [1:0]                      m_status_reg;
    logic [4:0]                      m_count_reg;
    logic                            m_is_empty_reg;
    logic                            s_fire;
    logic                            out_load;
    logic                            is_full;
    logic                            is_void;
    logic [CMP_W-1:0]                pos_x;
    logic [CMP_W-1:0]                cnt_x;
    logic [CMP_W-1:0]                last_x;
    logic [CMP_W-1:0]                eff_pos;
    logic [DATA_WIDTH-1:0]           word_d;
    logic [DATA_WIDTH-1:0]           red_word;
    logic [DEPTH-1:0][DATA_WIDTH-1:0] cell_data;
    logic [DEPTH-1:0][DATA_WIDTH-1:0] cell_tap;
    cell_ctl_t                       ctl;

    assign s_fire  = s_valid && s_ready;
    assign is_full = (count_reg == FULL_CNT);
    assign is_void = (count_reg == '0);
    assign word_d  = DATA_WIDTH'(s_word_in);

    // Clamp the position to the end of the held words
    assign pos_x  = CMP_W'(s_position);
    assign cnt_x  = CMP_W'(count_reg);
    assign last_x = cnt_x - CMP_W'(1);
    always_comb begin
        if (s_func == OP_INSERT) begin
            eff_pos = (pos_x > cnt_x) ? cnt_x : pos_x;
        end else begin
            eff_pos = (pos_x > last_x) ? last_x : pos_x;
        end
    end

    // Decode the operation into cell controls
    always_comb begin
        ctl.load = s_fire;
        ctl.ins  = s_fire && (s_func == OP_INSERT) && !is_full;
        ctl.rem  = s_fire && (s_func == OP_REMOVE) && !is_void;
        ctl.wr   = s_fire && (s_func == OP_OVERWRITE) && !is_void;
        ctl.rd   = s_fire && (s_func == OP_READ) && !is_void;
    end

    // Chain of cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (i == 0) begin : g_head
            assign left_d = '0;
        end else begin : g_left
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_d = '0;
        end else begin : g_right
            assign right_d = cell_data[i+1];
        end

        isl_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CMP_W      (CMP_W),
            .INDEX      (i)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .eff_pos    (eff_pos),
            .word       (word_d),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .tap        (cell_tap[i])
        );
    end

    isl_reduce #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_reduce (
        .taps (cell_tap),
        .word (red_word)
    );

    // Controller: next state, count and status
    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        pend_status_next = pend_status_reg;
        out_load         = 1'b0;
        s_ready          = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_fire) begin
                    state_next = ST_BUSY;
                    if (s_func == OP_INSERT) begin
                        if (is_full) begin
                            pend_status_next = STAT_FULL;
                        end else begin
                            pend_status_next = STAT_OK;
                            count_next       = count_reg + CNT_W'(1);
                        end
                    end else if (is_void) begin
                        pend_status_next = STAT_EMPTY;
                    end else begin
                        pend_status_next = STAT_OK;
                        if (s_func == OP_REMOVE) begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
            end
            ST_BUSY: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_status_reg <= pend_status_next;
    end

    // Output register: load a finished result, drop it on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_word_out_reg <= 32'(red_word);
            m_status_reg   <= pend_status_reg;
            m_count_reg    <= 5'(count_reg);
            m_is_empty_reg <= (count_reg == '0);
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_word_out = m_word_out_reg;
    assign m_status   = m_status_reg;
    assign m_count    = m_count_reg;
    assign m_is_empty = m_is_empty_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("held count exceeds depth");

    a_fire_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == ST_BUSY) && !s_ready)
        else $error("input taken while an item is in flight");

    a_insert_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_func == OP_INSERT) && !is_full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the list");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && is_void && (s_func != OP_INSERT))
        |=> (pend_status_reg == STAT_EMPTY) && (count_reg == '0))
        else $error("operation on empty list not flagged");

    a_load_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten while stalled");

endmodule
